[src/gzip_header_parser_top_macros.svh]
// Assertion macros for the gzip header parser.
// Used by gzip_header_parser_top.sv; needs no other file.
`ifndef GZIP_HEADER_PARSER_TOP_MACROS_SVH
`define GZIP_HEADER_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GZHP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gzip header parser: implication check failed");
// Next-cycle implication, disabled during reset.
`define GZHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gzip header parser: next-cycle check failed");
`else
`define GZHP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GZHP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/gzhp_pkg.sv]
// Package for the gzip header parser: item types, codes and parser state.
// Has no dependencies; used by gzhp_step.sv and gzip_header_parser_top.sv.
`timescale 1ns / 1ps
package gzhp_pkg;

   typedef enum logic [2:0] {
      PH_FIXED   = 3'd0,
      PH_EXTRA   = 3'd1,
      PH_NAME    = 3'd2,
      PH_COMMENT = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_REJECT  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_MAGIC  = 3'd1,
      ERR_METHOD = 3'd2,
      ERR_ASCII  = 3'd3,
      ERR_CONT   = 3'd4,
      ERR_CRYPT  = 3'd5,
      ERR_TRUNC  = 3'd6
   } error_type;

   localparam logic [7:0] MAGIC_A        = 8'h1F;
   localparam logic [7:0] MAGIC_B        = 8'h8B;
   localparam logic [7:0] METHOD_DEFLATE = 8'd8;
   localparam logic [7:0] FL_ASCII       = 8'h01;
   localparam logic [7:0] FL_CONT        = 8'h02;
   localparam logic [7:0] FL_EXTRA       = 8'h04;
   localparam logic [7:0] FL_NAME        = 8'h08;
   localparam logic [7:0] FL_COMMENT     = 8'h10;
   localparam logic [7:0] FL_CRYPT       = 8'h20;

   localparam logic [3:0] POS_MAGIC_A = 4'd0;
   localparam logic [3:0] POS_MAGIC_B = 4'd1;
   localparam logic [3:0] POS_METHOD  = 4'd2;
   localparam logic [3:0] POS_FLAGS   = 4'd3;
   localparam logic [3:0] FIXED_LEN   = 4'd10;
   localparam logic [3:0] EXTRA_END   = 4'd12;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       stream_start;
      logic       stream_end;
   } req_item_type;

   typedef struct packed {
      logic [2:0] byte_kind;
      logic       data_start;
      logic [2:0] error_code;
   } rsp_item_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  fixed_position;
      logic [7:0]  flag_bits;
      logic [15:0] extra_remaining;
      logic        payload_seen;
      error_type   sticky_error;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:           PH_FIXED,
      fixed_position:  4'd0,
      flag_bits:       8'd0,
      extra_remaining: 16'd0,
      payload_seen:    1'b0,
      sticky_error:    ERR_NONE
   };

   // Part that follows the extra field.
   function automatic phase_type after_extra(input logic [7:0] flags);
      phase_type ph;
      if ((flags & FL_NAME) != 8'd0) begin
         ph = PH_NAME;
      end else if ((flags & FL_COMMENT) != 8'd0) begin
         ph = PH_COMMENT;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

   // Part that follows the ten fixed bytes.
   function automatic phase_type after_fixed(input logic [7:0] flags);
      phase_type ph;
      if ((flags & FL_EXTRA) != 8'd0) begin
         ph = PH_EXTRA;
      end else begin
         ph = after_extra(flags);
      end
      return ph;
   endfunction

endpackage

[src/gzip_header_parser_top.sv]
// Top level of the gzip header parser: input register, parser state and result register.
// Depends on gzhp_pkg, gzhp_step and gzip_header_parser_top_macros.svh.
`timescale 1ns / 1ps
// The block takes a compressed file one byte per item on the req_ channel and
// returns one result item per byte on the rsp_ channel, in the same order.
// Each result classes its byte (fixed header, extra field, name, comment,
// payload or rejected), marks the first payload byte, and carries the sticky
// error code as it stands after that byte. An item with stream_start set
// restarts the parser before its byte is handled.
// An accepted item is held in an input register; once the output register is
// empty or being taken, the byte is parsed against the held parser state and
// the result is written to the output register. The parser state is a single
// register updated once per byte, which sets the throughput at one item per
// cycle in both directions while the receiver does not stall.
// When the receiver stalls, the result register holds its item, the input
// register keeps at most one more, and req_stall rises only while both are
// full. Synchronous reset empties both registers and returns the parser to
// the start of the fixed header with no error.
module gzip_header_parser_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gzhp_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gzhp_pkg::rsp_item_type rsp_item
);
   import gzhp_pkg::*;
`include "gzip_header_parser_top_macros.svh"

   // Input stage.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_item_type    in_item_ff;
   req_item_type    in_item_in;

   // Parser state, advanced once for every byte that moves to the output.
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_step;

   // Output stage.
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_item_type    out_item_ff;
   rsp_item_type    out_item_in;
   rsp_item_type    step_result;

   logic            advance;
   logic            req_take;

   gzhp_step u_step (
      .item       (in_item_ff),
      .state_cur  (state_ff),
      .state_next (state_step),
      .result     (step_result)
   );

   // The held byte moves on when the output register is empty or is being taken.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         state_in     = state_step;
         out_item_in  = step_result;
         out_valid_in = 1'b1;
         in_valid_in  = 1'b0;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // A first-payload mark only ever sits on a payload byte.
   `GZHP_ASSERT_IMPLY(a_dstart_payload, clock, reset,
      rsp_valid && rsp_item.data_start, rsp_item.byte_kind == PH_PAYLOAD)
   // A rejected byte always carries an error code.
   `GZHP_ASSERT_IMPLY(a_reject_has_code, clock, reset,
      rsp_valid && rsp_item.byte_kind == PH_REJECT, rsp_item.error_code != ERR_NONE)
   // Any recorded error leaves the parser in the rejected phase.
   `GZHP_ASSERT_IMPLY(a_error_rejects, clock, reset,
      state_ff.sticky_error != ERR_NONE, state_ff.phase == PH_REJECT)
   // A byte that moves on always fills the output register.
   `GZHP_ASSERT_NEXT(a_advance_fills, clock, reset,
      advance, rsp_valid)

endmodule

[src/gzhp_step.sv]
// Per-byte header parsing logic: next parser state and the result item.
// Depends on gzhp_pkg.
`timescale 1ns / 1ps
module gzhp_step (
   input  gzhp_pkg::req_item_type    item,
   input  gzhp_pkg::parse_state_type state_cur,
   output gzhp_pkg::parse_state_type state_next,
   output gzhp_pkg::rsp_item_type    result
);
   import gzhp_pkg::*;

   parse_state_type cur;
   parse_state_type nxt;
   phase_type       kind;
   logic            dstart;
   logic [3:0]      pos_inc;
   logic [7:0]      b;

   always_comb begin
      cur     = item.stream_start ? STATE_RESET : state_cur;
      b       = item.byte_value;
      nxt     = cur;
      kind    = cur.phase;
      dstart  = 1'b0;
      pos_inc = cur.fixed_position + 4'd1;

      case (cur.phase)
         PH_FIXED: begin
            if (cur.fixed_position == POS_MAGIC_A && b != MAGIC_A) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_MAGIC;
            end else if (cur.fixed_position == POS_MAGIC_B && b != MAGIC_B) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_MAGIC;
            end else if (cur.fixed_position == POS_METHOD && b != METHOD_DEFLATE) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_METHOD;
            end else if (cur.fixed_position == POS_FLAGS && (b & FL_ASCII) != 8'd0) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_ASCII;
            end else if (cur.fixed_position == POS_FLAGS && (b & FL_CONT) != 8'd0) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_CONT;
            end else if (cur.fixed_position == POS_FLAGS && (b & FL_CRYPT) != 8'd0) begin
               nxt.phase = PH_REJECT;
               nxt.sticky_error = ERR_CRYPT;
            end else begin
               if (cur.fixed_position == POS_FLAGS) begin
                  nxt.flag_bits = b;
               end
               nxt.fixed_position = pos_inc;
               if (pos_inc >= FIXED_LEN) begin
                  nxt.phase = after_fixed(nxt.flag_bits);
               end
            end
            if (nxt.phase == PH_REJECT) begin
               kind = PH_REJECT;
            end
         end
         PH_EXTRA: begin
            if (cur.fixed_position < EXTRA_END) begin
               // Two little-endian length bytes come first.
               if (cur.fixed_position == FIXED_LEN) begin
                  nxt.extra_remaining = {8'd0, b};
               end else begin
                  nxt.extra_remaining = {cur.extra_remaining[15:8] | b,
                                         cur.extra_remaining[7:0]};
               end
               nxt.fixed_position = pos_inc;
               if (pos_inc == EXTRA_END && nxt.extra_remaining == 16'd0) begin
                  nxt.phase = after_extra(cur.flag_bits);
               end
            end else begin
               if (cur.extra_remaining != 16'd0) begin
                  nxt.extra_remaining = cur.extra_remaining - 16'd1;
               end
               if (nxt.extra_remaining == 16'd0) begin
                  nxt.phase = after_extra(cur.flag_bits);
               end
            end
         end
         PH_NAME: begin
            if (b == 8'd0) begin
               nxt.phase = ((cur.flag_bits & FL_COMMENT) != 8'd0) ? PH_COMMENT : PH_PAYLOAD;
            end
         end
         PH_COMMENT: begin
            if (b == 8'd0) begin
               nxt.phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (!cur.payload_seen) begin
               dstart = 1'b1;
               nxt.payload_seen = 1'b1;
            end
         end
         default: begin
            kind = PH_REJECT;
            nxt.phase = PH_REJECT;
         end
      endcase

      // The file ends before the header is complete.
      if (item.stream_end && kind != PH_PAYLOAD && kind != PH_REJECT &&
          nxt.phase != PH_PAYLOAD && nxt.sticky_error == ERR_NONE) begin
         nxt.phase = PH_REJECT;
         nxt.sticky_error = ERR_TRUNC;
      end

      state_next        = nxt;
      result.byte_kind  = kind;
      result.data_start = dstart;
      result.error_code = nxt.sticky_error;
   end

endmodule

[verif/tb_gzip_header_parser_top.sv]
// Self-checking testbench for gzip_header_parser_top: byte stimulus and a parse scoreboard.
// Depends on gzhp_pkg (item types, phase and error codes, header constants) and the parser RTL.
`timescale 1ns / 1ps
module tb_gzip_header_parser_top;
   import gzhp_pkg::*;

   // The run stops here no matter what; the limit lies above the slowest legal run,
   // even with every item meeting the longest gaps and stalls.
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int unsigned ITEM_TARGET  = 1850;
   // The parser registers a byte before it offers that byte's result.
   localparam int unsigned SETTLE_CYCLES = 8;

   // Scoreboard: tracks the header parse of the byte stream on its own and
   // holds the result items still owed by the block, oldest first.
   class gzip_parse_scoreboard;
      phase_type    part;
      logic [3:0]   hdr_pos;
      logic [7:0]   flags;
      logic [15:0]  extra_left;
      bit           payload_begun;
      error_type    err;
      rsp_item_type owed_q[$];
      int unsigned  fail_count;

      function new();
         restart();
         fail_count = 0;
      endfunction

      function void restart();
         part          = PH_FIXED;
         hdr_pos       = 4'd0;
         flags         = 8'd0;
         extra_left    = 16'd0;
         payload_begun = 1'b0;
         err           = ERR_NONE;
      endfunction

      function void fault(input error_type code);
         err  = code;
         part = PH_REJECT;
      endfunction

      // Next part once the extra field is done or absent.
      function phase_type part_after_extra();
         if ((flags & FL_NAME) != 8'd0) return PH_NAME;
         if ((flags & FL_COMMENT) != 8'd0) return PH_COMMENT;
         return PH_PAYLOAD;
      endfunction

      // Works out the result item that an accepted byte causes.
      function void note_input(input req_item_type it);
         phase_type    kind;
         bit           first_payload;
         logic [7:0]   b;
         rsp_item_type owed;
         b = it.byte_value;
         first_payload = 1'b0;
         if (it.stream_start) restart();
         kind = part;
         case (part)
            PH_FIXED: begin
               if (hdr_pos == POS_MAGIC_A && b != MAGIC_A) fault(ERR_MAGIC);
               else if (hdr_pos == POS_MAGIC_B && b != MAGIC_B) fault(ERR_MAGIC);
               else if (hdr_pos == POS_METHOD && b != METHOD_DEFLATE) fault(ERR_METHOD);
               else if (hdr_pos == POS_FLAGS && (b & FL_ASCII) != 8'd0) fault(ERR_ASCII);
               else if (hdr_pos == POS_FLAGS && (b & FL_CONT) != 8'd0) fault(ERR_CONT);
               else if (hdr_pos == POS_FLAGS && (b & FL_CRYPT) != 8'd0) fault(ERR_CRYPT);
               else begin
                  if (hdr_pos == POS_FLAGS) flags = b;
                  hdr_pos = hdr_pos + 4'd1;
                  if (hdr_pos >= FIXED_LEN) begin
                     part = ((flags & FL_EXTRA) != 8'd0) ? PH_EXTRA : part_after_extra();
                  end
               end
               if (part == PH_REJECT) kind = PH_REJECT;
            end
            PH_EXTRA: begin
               if (hdr_pos < EXTRA_END) begin
                  // Two length bytes, low byte first.
                  if (hdr_pos == FIXED_LEN) extra_left = {8'd0, b};
                  else extra_left = extra_left | {b, 8'd0};
                  hdr_pos = hdr_pos + 4'd1;
                  if (hdr_pos == EXTRA_END && extra_left == 16'd0) part = part_after_extra();
               end else begin
                  if (extra_left != 16'd0) extra_left = extra_left - 16'd1;
                  if (extra_left == 16'd0) part = part_after_extra();
               end
            end
            PH_NAME: begin
               if (b == 8'd0) part = ((flags & FL_COMMENT) != 8'd0) ? PH_COMMENT : PH_PAYLOAD;
            end
            PH_COMMENT: begin
               if (b == 8'd0) part = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (!payload_begun) begin
                  first_payload = 1'b1;
                  payload_begun = 1'b1;
               end
            end
            default: begin
               kind = PH_REJECT;
               part = PH_REJECT;
            end
         endcase
         // The file ran out before the header was complete.
         if (it.stream_end && kind != PH_PAYLOAD && kind != PH_REJECT &&
             part != PH_PAYLOAD && err == ERR_NONE) fault(ERR_TRUNC);
         owed.byte_kind  = kind;
         owed.data_start = first_payload;
         owed.error_code = err;
         owed_q.push_back(owed);
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type want;
         if (owed_q.size() == 0) begin
            $error("result item with none owed: byte_kind %0d data_start %0d error_code %0d",
                   got.byte_kind, got.data_start, got.error_code);
            fail_count++;
            return;
         end
         want = owed_q.pop_front();
         if (got.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, actual %0d", want.byte_kind, got.byte_kind);
            fail_count++;
         end
         if (got.data_start !== want.data_start) begin
            $error("data_start: expected %0d, actual %0d", want.data_start, got.data_start);
            fail_count++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   gzip_parse_scoreboard sb = new();
   int unsigned          cycle_count = 0;
   int unsigned          items_sent  = 0;
   bit                   idle_on     = 1'b1;
   req_item_type         stream_q[$];

   gzip_header_parser_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge, before any of this edge's
   // updates land, so an item counts exactly when valid is high and stall low.
   // A byte's result cannot show up in the same cycle as the byte itself.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_input(req_item);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: stall runs alternate with free runs; some free runs are long
   // so the parser also sees stretches with no back pressure at all.
   initial begin : rsp_stall_gen
      int unsigned n;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 4) == 0) n = $urandom_range(20, 80);
         else n = $urandom_range(1, 6);
         repeat (n) @(posedge clock);
      end
   end

   // Offers one item, optionally after an idle gap, and returns at the edge
   // where it was taken. A back-to-back item only updates the payload, so
   // valid never gets two assignments in one step.
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      req_item_type it;
      it.byte_value   = b;
      it.stream_start = first;
      it.stream_end   = last;
      send_item(it);
   endtask

   // Holds the sender off until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Builds one random file in stream_q. Most are well-formed headers with random
   // flags, lengths and content; some get one of the four leading bytes damaged,
   // get cut short, lack the start mark or run past their end, and a few are noise.
   task automatic build_stream();
      logic [7:0]  body[$];
      logic [7:0]  fl;
      logic [15:0] xlen;
      int unsigned r, cut, k;
      bit          closed, unmarked;
      req_item_type it;
      stream_q.delete();
      if ($urandom_range(0, 99) < 5) begin
         repeat ($urandom_range(1, 6)) begin
            it.byte_value   = 8'($urandom_range(0, 255));
            it.stream_start = ($urandom_range(0, 3) == 0);
            it.stream_end   = ($urandom_range(0, 3) == 0);
            stream_q.push_back(it);
         end
         return;
      end
      fl = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) != 0) fl = fl & ~(FL_ASCII | FL_CONT | FL_CRYPT);
      body.push_back(MAGIC_A);
      body.push_back(MAGIC_B);
      body.push_back(METHOD_DEFLATE);
      body.push_back(fl);
      repeat (6) body.push_back(8'($urandom_range(0, 255)));
      if ((fl & FL_EXTRA) != 8'd0) begin
         r = $urandom_range(0, 99);
         if (r < 20) xlen = 16'd0;
         else if (r < 95) xlen = 16'($urandom_range(1, 6));
         else xlen = 16'($urandom_range(7, 300));
         body.push_back(xlen[7:0]);
         body.push_back(xlen[15:8]);
         repeat (xlen) body.push_back(8'($urandom_range(0, 255)));
      end
      if ((fl & FL_NAME) != 8'd0) begin
         repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(1, 255)));
         body.push_back(8'd0);
      end
      if ((fl & FL_COMMENT) != 8'd0) begin
         repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(1, 255)));
         body.push_back(8'd0);
      end
      repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 12) begin
         body[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 15) begin
         cut = $urandom_range(1, body.size() - 1);
         while (body.size() > cut) void'(body.pop_back());
      end
      closed   = ($urandom_range(0, 9) != 0);
      unmarked = ($urandom_range(0, 29) == 0);
      for (k = 0; k < body.size(); k++) begin
         it.byte_value   = body[k];
         it.stream_start = (k == 0) && !unmarked;
         it.stream_end   = (k == body.size() - 1) && closed;
         stream_q.push_back(it);
      end
      // Bytes past the end mark without a new start.
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            it.byte_value   = 8'($urandom_range(0, 255));
            it.stream_start = 1'b0;
            it.stream_end   = 1'b0;
            stream_q.push_back(it);
         end
      end
   endtask

   initial begin : main
      logic [7:0] fl;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: a full header with extra field, name and comment (the two
      // top flag bits set, which must be ignored), payload that ends on the
      // end mark, and one byte past the end.
      fl = FL_EXTRA | FL_NAME | FL_COMMENT | 8'hC0;
      send_byte(MAGIC_A, 1'b1, 1'b0);
      send_byte(MAGIC_B, 1'b0, 1'b0);
      send_byte(METHOD_DEFLATE, 1'b0, 1'b0);
      send_byte(fl, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b0);
      send_byte(8'h41, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h55, 1'b0, 1'b0);
      // Bad first magic byte, then a byte of the rejected stream.
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(MAGIC_A, 1'b0, 1'b0);
      // Bad second magic byte.
      send_byte(MAGIC_A, 1'b1, 1'b0);
      send_byte(8'h8A, 1'b0, 1'b0);
      // Method other than deflate.
      send_byte(MAGIC_A, 1'b1, 1'b0);
      send_byte(MAGIC_B, 1'b0, 1'b0);
      send_byte(8'h07, 1'b0, 1'b0);
      drain_results();

      // Random files until the item budget is spent. Some files go out with
      // no idling at all; now and then the sender waits for the block to
      // empty out before going on.
      while (items_sent < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 99) < 70);
         build_stream();
         foreach (stream_q[i]) send_item(stream_q[i]);
         if ($urandom_range(0, 29) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+src
src/gzhp_pkg.sv
src/gzhp_step.sv
src/gzip_header_parser_top.sv
verif/tb_gzip_header_parser_top.sv
